// ===== rtl/rcfd_pkg.sv =====
// Package: shared types and constants for the remote control frame decoder.
`timescale 1ns / 1ps

package rcfd_pkg;

  localparam logic [7:0] START_BYTE = 8'h66;
  localparam logic [7:0] END_BYTE   = 8'h99;
  localparam logic [7:0] MID_BYTE   = 8'h80;

  localparam int unsigned PAYLOAD_LEN = 5;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned STORE_IDX_W = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_DATA_W-1:0] AUTO_LIMIT_RESET   = 16'd10000;
  localparam logic [CFG_DATA_W-1:0] MANUAL_LIMIT_RESET = 16'd256;

  typedef enum logic [0:0] {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_LIMIT   = 1'b0,
    REG_MANUAL_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2,
    PH_END   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_e;

  typedef struct packed {
    logic [0:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0]  roll_quarter_deg;
    logic signed [7:0]  pitch_quarter_deg;
    logic signed [11:0] yaw_tenths;
    logic [15:0]        thrust_value;
    logic [7:0]         command_bits;
    logic [1:0]         mode_event;
  } out_item_t;

  typedef struct packed {
    logic [7:0] roll;
    logic [7:0] pitch;
    logic [7:0] thrust;
    logic [7:0] yaw;
    logic [7:0] command;
  } frame_t;

endpackage

// ===== rtl/rcfd_front.sv =====
// Front end: byte parser that collects and checks frames and pushes good ones.
`timescale 1ns / 1ps

module rcfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcfd_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output rcfd_pkg::frame_t   frame_o
);

  rcfd_pkg::phase_e                  phase_q, phase_d;
  logic [rcfd_pkg::COUNT_W-1:0]      count_q, count_d;
  logic [7:0]                        xor_q, xor_d;
  logic [7:0]                        store_q [rcfd_pkg::PAYLOAD_LEN];
  logic                              accept;
  logic                              store_en;
  logic [rcfd_pkg::COUNT_W-1:0]      count_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_inc  = count_q + rcfd_pkg::COUNT_W'(1);

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    xor_d    = xor_q;
    store_en = 1'b0;
    push_o   = 1'b0;
    if (accept) begin
      if (in_item_i.operation == rcfd_pkg::OP_TIMEOUT) begin
        phase_d = rcfd_pkg::PH_HUNT;
      end else begin
        unique case (phase_q)
          rcfd_pkg::PH_HUNT: begin
            if (in_item_i.rx_byte == rcfd_pkg::START_BYTE) begin
              count_d = '0;
              xor_d   = '0;
              phase_d = rcfd_pkg::PH_DATA;
            end
          end
          rcfd_pkg::PH_DATA: begin
            store_en = 1'b1;
            xor_d    = xor_q ^ in_item_i.rx_byte;
            count_d  = count_inc;
            if (count_inc >= rcfd_pkg::COUNT_W'(rcfd_pkg::PAYLOAD_LEN)) begin
              phase_d = rcfd_pkg::PH_CHECK;
            end
          end
          rcfd_pkg::PH_CHECK: begin
            phase_d = (xor_q == in_item_i.rx_byte) ? rcfd_pkg::PH_END : rcfd_pkg::PH_HUNT;
          end
          rcfd_pkg::PH_END: begin
            phase_d = rcfd_pkg::PH_HUNT;
            push_o  = (in_item_i.rx_byte == rcfd_pkg::END_BYTE);
          end
          default: phase_d = rcfd_pkg::PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rcfd_pkg::PH_HUNT;
      count_q <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en && count_q < rcfd_pkg::COUNT_W'(rcfd_pkg::PAYLOAD_LEN)) begin
      store_q[count_q[rcfd_pkg::STORE_IDX_W-1:0]] <= in_item_i.rx_byte;
    end
  end

  assign frame_o.roll    = store_q[0];
  assign frame_o.pitch   = store_q[1];
  assign frame_o.thrust  = store_q[2];
  assign frame_o.yaw     = store_q[3];
  assign frame_o.command = store_q[4];

endmodule

// ===== rtl/rcfd_queue.sv =====
// Queue: short frame FIFO between the parser and the decode stage.
`timescale 1ns / 1ps

module rcfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rcfd_pkg::frame_t push_frame_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output rcfd_pkg::frame_t pop_frame_o
);

  rcfd_pkg::frame_t              mem_q [rcfd_pkg::QUEUE_DEPTH];
  logic [rcfd_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rcfd_pkg::QCNT_W-1:0]   count_q;
  logic                          do_push, do_pop;

  assign full_o      = (count_q == rcfd_pkg::QCNT_W'(rcfd_pkg::QUEUE_DEPTH));
  assign valid_o     = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_frame_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + rcfd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + rcfd_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + rcfd_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - rcfd_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

endmodule

// ===== rtl/rcfd_back.sv =====
// Back end: frame decode, mode event, limit registers and output register.
`timescale 1ns / 1ps

module rcfd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                q_valid_i,
  input  rcfd_pkg::frame_t                    q_frame_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rcfd_pkg::out_item_t                 out_item_o
);

  logic [rcfd_pkg::CFG_DATA_W-1:0] auto_limit_q, manual_limit_q;
  logic [15:0]                     prev_thrust_q;
  logic [15:0]                     thrust;
  logic                            out_valid_q;
  rcfd_pkg::out_item_t             out_q, out_d;
  rcfd_pkg::mode_e                 mode;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign thrust  = {q_frame_i.thrust, 8'h00};

  always_comb begin
    mode = rcfd_pkg::MODE_NONE;
    if (q_frame_i.thrust == rcfd_pkg::MID_BYTE && prev_thrust_q < auto_limit_q) begin
      mode = rcfd_pkg::MODE_AUTO;
    end else if (q_frame_i.thrust == 8'h00 && prev_thrust_q > manual_limit_q) begin
      mode = rcfd_pkg::MODE_MANUAL;
    end
  end

  always_comb begin
    out_d.roll_quarter_deg  = q_frame_i.roll ^ rcfd_pkg::MID_BYTE;
    out_d.pitch_quarter_deg = q_frame_i.pitch ^ rcfd_pkg::MID_BYTE;
    out_d.yaw_tenths        = {q_frame_i.yaw ^ rcfd_pkg::MID_BYTE, 4'h0};
    out_d.thrust_value      = thrust;
    out_d.command_bits      = q_frame_i.command;
    out_d.mode_event        = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_limit_q   <= rcfd_pkg::AUTO_LIMIT_RESET;
      manual_limit_q <= rcfd_pkg::MANUAL_LIMIT_RESET;
      prev_thrust_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rcfd_pkg::REG_AUTO_LIMIT:   auto_limit_q   <= cfg_data_i;
          rcfd_pkg::REG_MANUAL_LIMIT: manual_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (q_pop_o) begin
        prev_thrust_q <= thrust;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/remote_control_frame_decoder.sv =====
// Top level: remote control frame decoder, parser front end, queue, decode back end.
//
//   channel | dir | handshake                  | payload
//   in      | in  | in_valid_i / in_ready_o    | in_item_i (operation, rx_byte)
//   out     | out | out_valid_o / out_ready_i  | out_item_o (decoded frame)
//   cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle while the frame queue is not full; a good frame enters the queue at
// the edge that takes its end byte, then the output register once the output is free.
// Reset clears the parser, queue and previous thrust, and sets the limit registers to their reset values.
// The parser stalls input only when the two-entry frame queue is full.
`timescale 1ns / 1ps

module remote_control_frame_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rcfd_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rcfd_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic             push, q_full, q_valid, q_pop;
  rcfd_pkg::frame_t push_frame, pop_frame;

  assign cfg_ready_o = 1'b1;

  rcfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .frame_o    (push_frame)
  );

  rcfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_frame_o  (pop_frame)
  );

  rcfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_frame_i   (pop_frame),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
